>>> rtl/ncd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ncd_pkg;

    // sizing of the dispatcher
    localparam int NUM_CARS    = 8;
    localparam int NUM_FLOORS  = 64;
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 3;

    localparam int CAR_W   = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    localparam int FLOOR_W = $clog2(NUM_FLOORS);
    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] CAR_COUNT_RST = 4'd8;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_POST     = 2'd0,
        OP_STATUS   = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    // request queue select
    typedef enum logic [1:0] {
        Q_UP   = 2'd0,
        Q_DOWN = 2'd1,
        Q_CAR  = 2'd2
    } t_qsel;

    // result status codes
    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_ASSIGNED = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_UPDATED  = 3'd4
    } t_status;

    // one queued request
    typedef struct packed {
        logic [FLOOR_W-1:0] floor;
        logic               up;
        logic               from_car;
        logic [2:0]         origin;
    } t_req;

    // classified command from front to back
    typedef struct packed {
        t_op                op;
        t_qsel              qsel;
        t_req               req;
        logic               tab_we;
        logic [CAR_W-1:0]   car;
        logic [FLOOR_W-1:0] car_floor;
        logic [1:0]         car_motion;
    } t_cmd;

    // one result transaction
    typedef struct packed {
        t_status    status;
        logic [2:0] car;
        logic [5:0] floor;
        logic       up;
        logic       from_car;
        logic [2:0] origin;
        logic [5:0] distance;
        logic       pref;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/ncd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ncd_front (
    input  wire logic                i_in_valid,
    input  wire logic [1:0]          i_operation,
    input  wire logic [5:0]          i_request_floor,
    input  wire logic                i_from_car,
    input  wire logic                i_going_up,
    input  wire logic [2:0]          i_requesting_car,
    input  wire logic [2:0]          i_status_car,
    input  wire logic [5:0]          i_car_floor,
    input  wire logic [1:0]          i_car_motion,
    input  wire logic                i_q_full,
    output logic                     o_in_stall,
    output logic                     o_push,
    output ncd_pkg::t_cmd            o_cmd
);

    // saturate a floor to the top of the building
    function automatic logic [ncd_pkg::FLOOR_W-1:0] clamp_floor(input logic [5:0] f);
        if (int'(f) >= ncd_pkg::NUM_FLOORS) begin
            return ncd_pkg::FLOOR_W'(ncd_pkg::NUM_FLOORS - 1);
        end else begin
            return ncd_pkg::FLOOR_W'(f);
        end
    endfunction

    // accept while the command queue has room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // classify the transaction
    always_comb begin
        o_cmd              = '0;
        o_cmd.op           = ncd_pkg::t_op'(i_operation);
        o_cmd.req.floor    = clamp_floor(i_request_floor);
        o_cmd.req.up       = i_going_up;
        o_cmd.req.from_car = i_from_car;
        o_cmd.req.origin   = i_from_car ? i_requesting_car : 3'd0;
        if (i_from_car) begin
            o_cmd.qsel = ncd_pkg::Q_CAR;
        end else if (i_going_up) begin
            o_cmd.qsel = ncd_pkg::Q_UP;
        end else begin
            o_cmd.qsel = ncd_pkg::Q_DOWN;
        end
        o_cmd.tab_we     = int'(i_status_car) < ncd_pkg::NUM_CARS;
        o_cmd.car        = ncd_pkg::CAR_W'(i_status_car);
        o_cmd.car_floor  = clamp_floor(i_car_floor);
        o_cmd.car_motion = i_car_motion;
    end

endmodule

`default_nettype wire

>>> rtl/ncd_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ncd_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ncd_pkg::t_cmd i_data,
    output logic               o_full,
    output logic               o_valid,
    output ncd_pkg::t_cmd      o_data,
    input  wire logic          i_pop
);

    ncd_pkg::t_cmd r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rd];

    // occupancy
    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ncd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ncd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [3:0]       i_cfg_wr_data,
    input  wire logic             i_cmd_valid,
    input  wire ncd_pkg::t_cmd    i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output ncd_pkg::t_result      o_out
);

    localparam logic [1:0] MOT_IDLE = 2'd0;
    localparam logic [1:0] MOT_UP   = 2'd1;
    localparam logic [1:0] MOT_DOWN = 2'd2;

    localparam int CAR_W   = ncd_pkg::CAR_W;
    localparam int FLOOR_W = ncd_pkg::FLOOR_W;
    localparam int HEAD_W  = ncd_pkg::HEAD_W;
    localparam int QCNT_W  = ncd_pkg::QCNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    function automatic logic [HEAD_W-1:0] ptr_next(input logic [HEAD_W-1:0] p);
        if (p == HEAD_W'(ncd_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    t_state                r_state, n_state;
    logic [CAR_W-1:0]      r_idx, n_idx;
    logic                  r_pref_found, n_pref_found;
    logic [CAR_W-1:0]      r_pref_idx, n_pref_idx;
    logic [FLOOR_W-1:0]    r_pref_d, n_pref_d;
    logic [CAR_W-1:0]      r_all_idx, n_all_idx;
    logic [FLOOR_W-1:0]    r_all_d, n_all_d;
    logic                  r_out_valid, n_out_valid;
    ncd_pkg::t_result      r_out, n_out;
    ncd_pkg::t_req         r_rd_data;
    logic [3:0]            r_car_count;

    ncd_pkg::t_req         r_mem [ncd_pkg::NUM_QUEUES][ncd_pkg::QUEUE_DEPTH];
    logic [HEAD_W-1:0]     r_head [ncd_pkg::NUM_QUEUES];
    logic [HEAD_W-1:0]     r_tail [ncd_pkg::NUM_QUEUES];
    logic [QCNT_W-1:0]     r_qcount [ncd_pkg::NUM_QUEUES];
    logic [FLOOR_W-1:0]    r_floor_tab [ncd_pkg::NUM_CARS];
    logic [1:0]            r_motion_tab [ncd_pkg::NUM_CARS];

    logic                  out_free;
    logic                  up_pend, down_pend, car_pend, any_pend;
    ncd_pkg::t_qsel        pop_sel, op_q;
    logic                  q_full;
    logic                  do_push, do_pop, tab_write;
    logic [CAR_W-1:0]      last_idx;
    logic [FLOOR_W-1:0]    cur_floor, gap;
    logic [1:0]            cur_mot;
    logic                  eligible;
    logic [FLOOR_W-1:0]    best_d;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // queue status and selection
    assign out_free  = !r_out_valid || !i_out_stall;
    assign up_pend   = r_qcount[ncd_pkg::Q_UP] != '0;
    assign down_pend = r_qcount[ncd_pkg::Q_DOWN] != '0;
    assign car_pend  = r_qcount[ncd_pkg::Q_CAR] != '0;
    assign any_pend  = up_pend || down_pend || car_pend;
    assign pop_sel   = up_pend ? ncd_pkg::Q_UP : (down_pend ? ncd_pkg::Q_DOWN : ncd_pkg::Q_CAR);
    assign op_q      = (i_cmd.op == ncd_pkg::OP_DISPATCH) ? pop_sel : i_cmd.qsel;
    assign q_full    = r_qcount[op_q] == QCNT_W'(ncd_pkg::QUEUE_DEPTH);

    // last car taking part in dispatch
    always_comb begin
        if (r_car_count == 4'd0) begin
            last_idx = '0;
        end else if (int'(r_car_count) > ncd_pkg::NUM_CARS) begin
            last_idx = CAR_W'(ncd_pkg::NUM_CARS - 1);
        end else begin
            last_idx = CAR_W'(r_car_count - 4'd1);
        end
    end

    // compare one car per cycle
    assign cur_floor = r_floor_tab[r_idx];
    assign cur_mot   = r_motion_tab[r_idx];
    assign gap       = (cur_floor > r_rd_data.floor) ? (cur_floor - r_rd_data.floor)
                                                     : (r_rd_data.floor - cur_floor);
    assign eligible  = (cur_mot == MOT_IDLE) || (cur_mot == MOT_UP && r_rd_data.up)
                    || (cur_mot == MOT_DOWN && !r_rd_data.up);
    assign best_d    = r_pref_found ? r_pref_d : r_all_d;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pref_found = r_pref_found;
        n_pref_idx   = r_pref_idx;
        n_pref_d     = r_pref_d;
        n_all_idx    = r_all_idx;
        n_all_d      = r_all_d;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        o_cmd_pop    = 1'b0;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        tab_write    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        ncd_pkg::OP_POST: begin
                            if (out_free) begin
                                o_cmd_pop   = 1'b1;
                                n_out_valid = 1'b1;
                                n_out       = '0;
                                if (!q_full) begin
                                    do_push      = 1'b1;
                                    n_out.status = ncd_pkg::ST_ACCEPTED;
                                end else begin
                                    n_out.status = ncd_pkg::ST_DROPPED;
                                end
                            end
                        end
                        ncd_pkg::OP_STATUS: begin
                            if (out_free) begin
                                o_cmd_pop    = 1'b1;
                                tab_write    = i_cmd.tab_we;
                                n_out_valid  = 1'b1;
                                n_out        = '0;
                                n_out.status = ncd_pkg::ST_UPDATED;
                            end
                        end
                        ncd_pkg::OP_DISPATCH: begin
                            if (any_pend) begin
                                o_cmd_pop    = 1'b1;
                                do_pop       = 1'b1;
                                n_idx        = '0;
                                n_pref_found = 1'b0;
                                n_state      = S_SCAN;
                            end else if (out_free) begin
                                o_cmd_pop    = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out        = '0;
                                n_out.status = ncd_pkg::ST_EMPTY;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                o_cmd_pop    = 1'b1;
                                n_out_valid  = 1'b1;
                                n_out        = '0;
                                n_out.status = ncd_pkg::ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (eligible && (!r_pref_found || gap < r_pref_d)) begin
                    n_pref_found = 1'b1;
                    n_pref_idx   = r_idx;
                    n_pref_d     = gap;
                end
                if (r_idx == '0 || gap < r_all_d) begin
                    n_all_idx = r_idx;
                    n_all_d   = gap;
                end
                if (r_idx == last_idx) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out          = '0;
                    n_out.status   = ncd_pkg::ST_ASSIGNED;
                    n_out.car      = 3'(r_pref_found ? r_pref_idx : r_all_idx);
                    n_out.floor    = 6'(r_rd_data.floor);
                    n_out.up       = r_rd_data.up;
                    n_out.from_car = r_rd_data.from_car;
                    n_out.origin   = r_rd_data.origin;
                    n_out.distance = (int'(best_d) > 63) ? 6'd63 : 6'(best_d);
                    n_out.pref     = r_pref_found;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state, pointers, car table and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_pref_found <= 1'b0;
            r_car_count  <= ncd_pkg::CAR_COUNT_RST;
            for (int q = 0; q < ncd_pkg::NUM_QUEUES; q++) begin
                r_head[q]   <= '0;
                r_tail[q]   <= '0;
                r_qcount[q] <= '0;
            end
            for (int c = 0; c < ncd_pkg::NUM_CARS; c++) begin
                r_floor_tab[c]  <= '0;
                r_motion_tab[c] <= MOT_IDLE;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_pref_found <= n_pref_found;
            if (i_cfg_wr_en) begin
                r_car_count <= i_cfg_wr_data;
            end
            if (do_push) begin
                r_tail[op_q]   <= ptr_next(r_tail[op_q]);
                r_qcount[op_q] <= r_qcount[op_q] + 1'b1;
            end
            if (do_pop) begin
                r_head[op_q]   <= ptr_next(r_head[op_q]);
                r_qcount[op_q] <= r_qcount[op_q] - 1'b1;
            end
            if (tab_write) begin
                r_floor_tab[i_cmd.car]  <= i_cmd.car_floor;
                r_motion_tab[i_cmd.car] <= i_cmd.car_motion;
            end
        end
    end

    // request memory and datapath registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pref_idx <= n_pref_idx;
        r_pref_d   <= n_pref_d;
        r_all_idx  <= n_all_idx;
        r_all_d    <= n_all_d;
        r_out      <= n_out;
        if (do_push) begin
            r_mem[op_q][r_tail[op_q]] <= i_cmd.req;
        end
        if (do_pop) begin
            r_rd_data <= r_mem[op_q][r_head[op_q]];
        end
    end

endmodule

`default_nettype wire

>>> rtl/nearest_car_elevator_dispatch.sv
// post, status and unused-code transactions pass through the command queue and the result register
// a dispatch loads its request into a register, scans the active cars one by one and then writes
// the result register
// throughput: one post or status transaction per cycle unless the output stalls; dispatch is bound
// by the serial scan of the car table, one car per cycle through a single distance calculation
// reset: request queues empty, every car at floor 0 and idle, car_count 8, queue memory undefined
`timescale 1ns / 1ps
`default_nettype none

module nearest_car_elevator_dispatch (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [3:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [5:0] i_request_floor,
    input  wire logic       i_from_car,
    input  wire logic       i_going_up,
    input  wire logic [2:0] i_requesting_car,
    input  wire logic [2:0] i_status_car,
    input  wire logic [5:0] i_car_floor,
    input  wire logic [1:0] i_car_motion,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [2:0]      o_status,
    output logic [2:0]      o_assigned_car,
    output logic [5:0]      o_assigned_floor,
    output logic            o_assigned_up,
    output logic            o_assigned_from_car,
    output logic [2:0]      o_origin_car,
    output logic [5:0]      o_car_distance,
    output logic            o_was_preferred
);

    logic             q_full;
    logic             push;
    ncd_pkg::t_cmd    front_cmd;
    logic             cmd_valid;
    ncd_pkg::t_cmd    cmd;
    logic             cmd_pop;
    ncd_pkg::t_result result;

    // classify incoming transactions
    ncd_front u_front (
        .i_in_valid       (i_in_valid),
        .i_operation      (i_operation),
        .i_request_floor  (i_request_floor),
        .i_from_car       (i_from_car),
        .i_going_up       (i_going_up),
        .i_requesting_car (i_requesting_car),
        .i_status_car     (i_status_car),
        .i_car_floor      (i_car_floor),
        .i_car_motion     (i_car_motion),
        .i_q_full         (q_full),
        .o_in_stall       (o_in_stall),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    // decoupling queue
    ncd_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (cmd_valid),
        .o_data  (cmd),
        .i_pop   (cmd_pop)
    );

    // execute commands
    ncd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out         (result)
    );

    // result fields
    assign o_status            = result.status;
    assign o_assigned_car      = result.car;
    assign o_assigned_floor    = result.floor;
    assign o_assigned_up       = result.up;
    assign o_assigned_from_car = result.from_car;
    assign o_origin_car        = result.origin;
    assign o_car_distance      = result.distance;
    assign o_was_preferred     = result.pref;

endmodule

`default_nettype wire

>>> sim/nearest_car_elevator_dispatch_tb.sv
`timescale 1ns / 1ps

module nearest_car_elevator_dispatch_tb;

    localparam logic [1:0] MOTION_IDLE = 2'd0;
    localparam logic [1:0] MOTION_UP   = 2'd1;
    localparam logic [1:0] MOTION_DOWN = 2'd2;
    localparam logic [1:0] MOTION_BUSY = 2'd3;

    localparam int DRAIN_LIMIT = 20000;

    // one input transaction as driven on the ports
    typedef struct packed {
        ncd_pkg::t_op op;
        logic [5:0]   request_floor;
        logic         from_car;
        logic         going_up;
        logic [2:0]   requesting_car;
        logic [2:0]   status_car;
        logic [5:0]   car_floor;
        logic [1:0]   car_motion;
    } t_stim;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [3:0] i_cfg_wr_data;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_operation;
    logic [5:0] i_request_floor;
    logic       i_from_car;
    logic       i_going_up;
    logic [2:0] i_requesting_car;
    logic [2:0] i_status_car;
    logic [5:0] i_car_floor;
    logic [1:0] i_car_motion;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [2:0] o_status;
    logic [2:0] o_assigned_car;
    logic [5:0] o_assigned_floor;
    logic       o_assigned_up;
    logic       o_assigned_from_car;
    logic [2:0] o_origin_car;
    logic [5:0] o_car_distance;
    logic       o_was_preferred;

    // dispatcher shadow state
    ncd_pkg::t_req    pending_up[$];
    ncd_pkg::t_req    pending_down[$];
    ncd_pkg::t_req    pending_cab[$];
    logic [5:0]       car_at_floor[ncd_pkg::NUM_CARS];
    logic [1:0]       car_moving[ncd_pkg::NUM_CARS];
    logic [3:0]       cars_in_service;

    ncd_pkg::t_result expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_errors = 0;
    int n_sent = 0;
    int n_assigned = 0;
    int n_fallback = 0;
    int n_dropped = 0;
    int n_empty = 0;
    int n_settings = 0;

    nearest_car_elevator_dispatch u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_operation         (i_operation),
        .i_request_floor     (i_request_floor),
        .i_from_car          (i_from_car),
        .i_going_up          (i_going_up),
        .i_requesting_car    (i_requesting_car),
        .i_status_car        (i_status_car),
        .i_car_floor         (i_car_floor),
        .i_car_motion        (i_car_motion),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_assigned_car      (o_assigned_car),
        .o_assigned_floor    (o_assigned_floor),
        .o_assigned_up       (o_assigned_up),
        .o_assigned_from_car (o_assigned_from_car),
        .o_origin_car        (o_origin_car),
        .o_car_distance      (o_car_distance),
        .o_was_preferred     (o_was_preferred)
    );

    always #5 i_clk = ~i_clk;

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // nearest-car dispatch prediction, applied in acceptance order
    function automatic ncd_pkg::t_result predict_outcome(input t_stim s);
        ncd_pkg::t_result r;
        ncd_pkg::t_req    req;
        int      n;
        int      best;
        int      best_gap;
        int      gap;
        int      i;
        bit      found;
        bit      eligible;
        r = '0;
        case (s.op)
            ncd_pkg::OP_POST: begin
                req.floor    = s.request_floor;
                req.up       = s.going_up;
                req.from_car = s.from_car;
                req.origin   = s.from_car ? s.requesting_car : 3'd0;
                r.status     = ncd_pkg::ST_ACCEPTED;
                if (s.from_car) begin
                    if (pending_cab.size() < ncd_pkg::QUEUE_DEPTH) pending_cab.push_back(req);
                    else r.status = ncd_pkg::ST_DROPPED;
                end else if (s.going_up) begin
                    if (pending_up.size() < ncd_pkg::QUEUE_DEPTH) pending_up.push_back(req);
                    else r.status = ncd_pkg::ST_DROPPED;
                end else begin
                    if (pending_down.size() < ncd_pkg::QUEUE_DEPTH) pending_down.push_back(req);
                    else r.status = ncd_pkg::ST_DROPPED;
                end
            end
            ncd_pkg::OP_STATUS: begin
                if (s.status_car < ncd_pkg::NUM_CARS) begin
                    car_at_floor[s.status_car] = s.car_floor;
                    car_moving[s.status_car]   = s.car_motion;
                end
                r.status = ncd_pkg::ST_UPDATED;
            end
            ncd_pkg::OP_DISPATCH: begin
                // up queue has priority, then down, then car requests
                if (pending_up.size() != 0) req = pending_up.pop_front();
                else if (pending_down.size() != 0) req = pending_down.pop_front();
                else if (pending_cab.size() != 0) req = pending_cab.pop_front();
                else begin
                    r.status = ncd_pkg::ST_EMPTY;
                    return r;
                end
                n = (cars_in_service == 0) ? 1 :
                    (cars_in_service > ncd_pkg::NUM_CARS) ? ncd_pkg::NUM_CARS : cars_in_service;
                found = 1'b0;
                best = 0;
                best_gap = 0;
                // first pass: idle or heading the same way
                for (i = 0; i < n; i++) begin
                    gap = (car_at_floor[i] > req.floor) ? car_at_floor[i] - req.floor
                                                        : req.floor - car_at_floor[i];
                    eligible = (car_moving[i] == MOTION_IDLE) ||
                               (car_moving[i] == MOTION_UP && req.up) ||
                               (car_moving[i] == MOTION_DOWN && !req.up);
                    if (eligible && (!found || gap < best_gap)) begin
                        found = 1'b1;
                        best = i;
                        best_gap = gap;
                    end
                end
                r.pref = found;
                // fallback: nearest car of all
                if (!found) begin
                    for (i = 0; i < n; i++) begin
                        gap = (car_at_floor[i] > req.floor) ? car_at_floor[i] - req.floor
                                                            : req.floor - car_at_floor[i];
                        if (!found || gap < best_gap) begin
                            found = 1'b1;
                            best = i;
                            best_gap = gap;
                        end
                    end
                end
                r.status   = ncd_pkg::ST_ASSIGNED;
                r.car      = best[2:0];
                r.floor    = req.floor;
                r.up       = req.up;
                r.from_car = req.from_car;
                r.origin   = req.origin;
                r.distance = best_gap[5:0];
            end
            default: r.status = ncd_pkg::ST_EMPTY;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        ncd_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with nothing expected, status %0d", o_status);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("assigned_car", want.car, o_assigned_car);
                check_field("assigned_floor", want.floor, o_assigned_floor);
                check_field("assigned_up", want.up, o_assigned_up);
                check_field("assigned_from_car", want.from_car, o_assigned_from_car);
                check_field("origin_car", want.origin, o_origin_car);
                check_field("car_distance", want.distance, o_car_distance);
                check_field("was_preferred", want.pref, o_was_preferred);
                case (want.status)
                    ncd_pkg::ST_ASSIGNED: begin
                        n_assigned++;
                        if (!want.pref) n_fallback++;
                    end
                    ncd_pkg::ST_DROPPED: n_dropped++;
                    ncd_pkg::ST_EMPTY:   n_empty++;
                    default: ;
                endcase
            end
        end
    end

    // floors biased toward the ends of the building and toward ties
    function automatic logic [5:0] pick_floor();
        logic [5:0] f;
        case ($urandom_range(3))
            0: f = 6'($urandom_range(7));
            1: f = 6'($urandom_range(63, 56));
            default: f = 6'($urandom_range(63));
        endcase
        return f;
    endfunction

    function automatic t_stim random_fields();
        t_stim s;
        s.op             = ncd_pkg::t_op'(2'($urandom_range(3)));
        s.request_floor  = 6'($urandom_range(63));
        s.from_car       = 1'($urandom_range(1));
        s.going_up       = 1'($urandom_range(1));
        s.requesting_car = 3'($urandom_range(7));
        s.status_car     = 3'($urandom_range(7));
        s.car_floor      = 6'($urandom_range(63));
        s.car_motion     = 2'($urandom_range(3));
        return s;
    endfunction

    function automatic t_stim post_item(input logic [5:0] fl, input logic fc,
                                        input logic up, input logic [2:0] rc);
        t_stim s;
        s = random_fields();
        s.op             = ncd_pkg::OP_POST;
        s.request_floor  = fl;
        s.from_car       = fc;
        s.going_up       = up;
        s.requesting_car = rc;
        return s;
    endfunction

    function automatic t_stim status_item(input logic [2:0] car, input logic [5:0] fl,
                                          input logic [1:0] motion);
        t_stim s;
        s = random_fields();
        s.op         = ncd_pkg::OP_STATUS;
        s.status_car = car;
        s.car_floor  = fl;
        s.car_motion = motion;
        return s;
    endfunction

    function automatic t_stim op_item(input ncd_pkg::t_op op);
        t_stim s;
        s = random_fields();
        s.op = op;
        return s;
    endfunction

    // mixed traffic: posts, car status, dispatches and a little noise
    function automatic t_stim traffic_item(input int busy_pct);
        int         roll;
        logic [1:0] motion;
        roll = $urandom_range(99);
        motion = 2'($urandom_range(3));
        if ($urandom_range(99) < busy_pct) motion = MOTION_BUSY;
        if (roll < 40)
            return post_item(pick_floor(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                             3'($urandom_range(7)));
        else if (roll < 65)
            return status_item(3'($urandom_range(7)), pick_floor(), motion);
        else if (roll < 95)
            return op_item(ncd_pkg::OP_DISPATCH);
        return op_item(ncd_pkg::OP_NONE);
    endfunction

    // drive one transaction and hold it until accepted
    task automatic send_txn(input t_stim s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= s.op;
        i_request_floor  <= s.request_floor;
        i_from_car       <= s.from_car;
        i_going_up       <= s.going_up;
        i_requesting_car <= s.requesting_car;
        i_status_car     <= s.status_car;
        i_car_floor      <= s.car_floor;
        i_car_motion     <= s.car_motion;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_outcome(s));
        n_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d result transactions never arrived", expected_results.size());
            n_errors++;
            expected_results.delete();
        end
    endtask

    // register write only while the dispatcher is idle
    task automatic write_car_count(input logic [3:0] value);
        wait_drained();
        repeat (12) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cars_in_service = value;
        n_settings++;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
    endtask

    // empty dispatch, unused code, queue priority, direction preference, origin
    task automatic test_directed();
        set_idling(0);
        send_txn(op_item(ncd_pkg::OP_DISPATCH));
        send_txn(op_item(ncd_pkg::OP_NONE));
        send_txn(post_item(6'd63, 1'b0, 1'b1, 3'd7));
        send_txn(op_item(ncd_pkg::OP_DISPATCH));
        send_txn(status_item(3'd7, 6'd63, MOTION_DOWN));
        send_txn(status_item(3'd3, 6'd40, MOTION_UP));
        send_txn(status_item(3'd5, 6'd0, MOTION_BUSY));
        send_txn(post_item(6'd0, 1'b0, 1'b0, 3'd0));
        send_txn(post_item(6'd63, 1'b1, 1'b1, 3'd7));
        send_txn(post_item(6'd50, 1'b0, 1'b1, 3'd0));
        repeat (3) send_txn(op_item(ncd_pkg::OP_DISPATCH));
        send_txn(post_item(6'd0, 1'b1, 1'b0, 3'd0));
        repeat (2) send_txn(op_item(ncd_pkg::OP_DISPATCH));
        wait_drained();
    endtask

    // overfill each queue, then drain it
    task automatic test_queue_overflow();
        int kind;
        set_idling(2);
        for (kind = 0; kind < 3; kind++) begin
            repeat (ncd_pkg::QUEUE_DEPTH + 2)
                send_txn(post_item(pick_floor(), kind == 2, kind == 0, 3'($urandom_range(7))));
            repeat (ncd_pkg::QUEUE_DEPTH + 2) send_txn(op_item(ncd_pkg::OP_DISPATCH));
        end
        wait_drained();
    endtask

    // dispatch across car count settings, the extremes among them
    task automatic test_car_count_settings();
        logic [3:0] counts[5];
        int         k;
        counts = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd0};
        counts[4] = 4'($urandom_range(7, 2));
        for (k = 0; k < 5; k++) begin
            write_car_count(counts[k]);
            set_idling(k);
            repeat (60) send_txn(traffic_item(50));
        end
        wait_drained();
    endtask

    // long random traffic under each idling pattern
    task automatic test_random_traffic();
        int phase;
        int i;
        for (phase = 0; phase < 4; phase++) begin
            write_car_count(4'($urandom_range(15)));
            set_idling(phase);
            for (i = 0; i < 300; i++) begin
                // sender holds off until every result is back
                if (i == 150) wait_drained();
                send_txn(traffic_item(15 + 25 * phase));
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_wr_en      <= 1'b0;
        i_cfg_wr_data    <= 4'd0;
        i_in_valid       <= 1'b0;
        i_operation      <= ncd_pkg::OP_NONE;
        i_request_floor  <= 6'd0;
        i_from_car       <= 1'b0;
        i_going_up       <= 1'b0;
        i_requesting_car <= 3'd0;
        i_status_car     <= 3'd0;
        i_car_floor      <= 6'd0;
        i_car_motion     <= MOTION_IDLE;
        for (int c = 0; c < ncd_pkg::NUM_CARS; c++) begin
            car_at_floor[c] = 6'd0;
            car_moving[c]   = MOTION_IDLE;
        end
        cars_in_service = ncd_pkg::CAR_COUNT_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_queue_overflow();
        test_car_count_settings();
        test_random_traffic();

        repeat (30) @(posedge i_clk);
        $display("covered %0d transactions over %0d car count settings and four idling patterns",
                 n_sent, n_settings);
        $display("%0d assigned (%0d by fallback), %0d dropped on full queue, %0d empty",
                 n_assigned, n_fallback, n_dropped, n_empty);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/ncd_pkg.sv
rtl/ncd_front.sv
rtl/ncd_cmd_queue.sv
rtl/ncd_back.sv
rtl/nearest_car_elevator_dispatch.sv
sim/nearest_car_elevator_dispatch_tb.sv
